// ===== rtl/plbu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_pkg
// Shared types and constants for the price-level book update block.
// ----------------------------------------------------------------------------
package plbu_pkg;

   localparam int unsigned LEVEL_COUNT_DEFAULT = 1024;

   localparam int unsigned PRICE_W = 32;
   localparam int unsigned DELTA_W = 64;
   localparam int unsigned QTY_W   = 63;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_PRICE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHEST_PRICE = 1'b1;

   localparam logic [PRICE_W-1:0] LOWEST_PRICE_RESET  = 32'sd0;
   localparam logic [PRICE_W-1:0] HIGHEST_PRICE_RESET = 32'sd1023;

   // Side codes
   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   // Status codes
   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

   // Per-side write enables of the level store
   typedef struct packed {
      logic bid;
      logic ask;
   } plbu_wr_en_type;

endpackage

// ===== rtl/price_level_book_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_update
// Price-level order book: bid and ask quantity per price in a window.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   req_side, req_price, req_qty_delta           start & !busy
//  response  rsp_status, rsp_bid_quantity, rsp_ask_quantity  rsp_valid, 1 cycle
//  config    csr_index, csr_wdata                         csr_write
//
//  An item passes through window check and store read, read-modify-write,
//  response. The store read and the response are registered; a new item is
//  taken in the cycle its predecessor's response is shown. After reset a
//  clearing pass zeroes the store with busy high; configuration writes are
//  taken during it.
//  The receiver cannot stall: rsp_valid lasts exactly one cycle.
// ----------------------------------------------------------------------------
module price_level_book_update
   import plbu_pkg::*;
#(
   parameter int unsigned LEVEL_COUNT = LEVEL_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_side,
   input  logic [PRICE_W-1:0]   req_price,
   input  logic [DELTA_W-1:0]   req_qty_delta,
   output logic                 rsp_valid,
   output logic                 rsp_status,
   output logic [QTY_W-1:0]     rsp_bid_quantity,
   output logic [QTY_W-1:0]     rsp_ask_quantity,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(LEVEL_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LEVEL_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MODIFY,
      ST_RESPOND
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clear_addr_ff, clear_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [PRICE_W-1:0]   lowest_ff, highest_ff;

   logic                 side_ff;
   logic [PRICE_W-1:0]   price_ff;
   logic [DELTA_W-1:0]   delta_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic                 hit_ff;
   logic                 status_ff;
   logic [QTY_W-1:0]     bid_ff, ask_ff;

   logic                 accept;
   logic [PRICE_W:0]     offset;
   logic                 hit;
   logic [ADDR_W-1:0]    lookup_addr;

   plbu_wr_en_type       wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [QTY_W-1:0]     wr_bid, wr_ask;
   logic [QTY_W-1:0]     rd_bid, rd_ask;
   logic [QTY_W-1:0]     new_bid, new_ask;

   assign busy      = !(state_ff == ST_IDLE || state_ff == ST_RESPOND);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_bid_quantity = bid_ff;
   assign rsp_ask_quantity = ask_ff;

   // Window check on the captured price
   always_comb begin
      offset = {price_ff[PRICE_W-1], price_ff} - {lowest_ff[PRICE_W-1], lowest_ff};
      hit = ($signed(price_ff) >= $signed(lowest_ff))
         && ($signed(price_ff) <= $signed(highest_ff))
         && (offset < (PRICE_W+1)'(LEVEL_COUNT));
      lookup_addr = offset[ADDR_W-1:0];
   end

   // Store write port: clearing pass or write-back of a hit
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = '{bid: 1'b1, ask: 1'b1};
         wr_addr = clear_addr_ff;
         wr_bid  = '0;
         wr_ask  = '0;
      end else begin
         wr_en   = '{bid: (state_ff == ST_MODIFY) && hit_ff && (side_ff == SIDE_BID),
                     ask: (state_ff == ST_MODIFY) && hit_ff && (side_ff == SIDE_ASK)};
         wr_addr = addr_ff;
         wr_bid  = new_bid;
         wr_ask  = new_ask;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_RESPOND: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in     = ST_RESPOND;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= LOWEST_PRICE_RESET;
         highest_ff <= HIGHEST_PRICE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOWEST_PRICE:  lowest_ff  <= csr_wdata;
            CSR_HIGHEST_PRICE: highest_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         side_ff  <= req_side;
         price_ff <= req_price;
         delta_ff <= req_qty_delta;
      end
      if (state_ff == ST_LOOKUP) begin
         addr_ff <= lookup_addr;
         hit_ff  <= hit;
      end
      if (state_ff == ST_MODIFY) begin
         status_ff <= hit_ff ? STATUS_DONE : STATUS_OUTSIDE;
         bid_ff    <= hit_ff ? new_bid : '0;
         ask_ff    <= hit_ff ? new_ask : '0;
      end
   end

   plbu_level_mem #(
      .LEVEL_COUNT (LEVEL_COUNT),
      .ADDR_W      (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_bid  (wr_bid),
      .wr_ask  (wr_ask),
      .rd_addr (lookup_addr),
      .rd_bid  (rd_bid),
      .rd_ask  (rd_ask)
   );

   plbu_qty_update u_update (
      .side      (side_ff),
      .qty_delta (delta_ff),
      .cur_bid   (rd_bid),
      .cur_ask   (rd_ask),
      .new_bid   (new_bid),
      .new_ask   (new_ask)
   );

endmodule

// ===== rtl/plbu_level_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_level_mem
// Bid and ask quantity stores, one write port and one registered read port.
// ----------------------------------------------------------------------------
module plbu_level_mem
   import plbu_pkg::*;
#(
   parameter int unsigned LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
   parameter int unsigned ADDR_W      = $clog2(LEVEL_COUNT)
) (
   input  logic                clock,
   input  plbu_wr_en_type      wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [QTY_W-1:0]    wr_bid,
   input  logic [QTY_W-1:0]    wr_ask,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [QTY_W-1:0]    rd_bid,
   output logic [QTY_W-1:0]    rd_ask
);

   logic [QTY_W-1:0] bid_mem [LEVEL_COUNT];
   logic [QTY_W-1:0] ask_mem [LEVEL_COUNT];

   always_ff @(posedge clock) begin
      if (wr_en.bid) begin
         bid_mem[wr_addr] <= wr_bid;
      end
      rd_bid <= bid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en.ask) begin
         ask_mem[wr_addr] <= wr_ask;
      end
      rd_ask <= ask_mem[rd_addr];
   end

endmodule

// ===== rtl/plbu_qty_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_qty_update
// Adds a signed change to the chosen side, clamped at zero and at the maximum.
// ----------------------------------------------------------------------------
module plbu_qty_update
   import plbu_pkg::*;
(
   input  logic               side,
   input  logic [DELTA_W-1:0] qty_delta,
   input  logic [QTY_W-1:0]   cur_bid,
   input  logic [QTY_W-1:0]   cur_ask,
   output logic [QTY_W-1:0]   new_bid,
   output logic [QTY_W-1:0]   new_ask
);

   logic [QTY_W-1:0]   cur_qty;
   logic [DELTA_W:0]   sum;
   logic [QTY_W-1:0]   upd_qty;

   always_comb begin
      cur_qty = (side == SIDE_ASK) ? cur_ask : cur_bid;
      // 65-bit signed sum never wraps
      sum = {2'b00, cur_qty} + {qty_delta[DELTA_W-1], qty_delta};
      if (sum[DELTA_W]) begin
         upd_qty = '0;
      end else if (sum[DELTA_W-1]) begin
         upd_qty = QTY_MAX;
      end else begin
         upd_qty = sum[QTY_W-1:0];
      end
      new_bid = (side == SIDE_BID) ? upd_qty : cur_bid;
      new_ask = (side == SIDE_ASK) ? upd_qty : cur_ask;
   end

endmodule
